FILE: src/codepoint_glyph_hash_map_assert.svh
// assertion macros for the codepoint glyph hash map
`ifndef CODEPOINT_GLYPH_HASH_MAP_ASSERT_SVH
`define CODEPOINT_GLYPH_HASH_MAP_ASSERT_SVH

`ifndef SYNTH
`define CGH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CGH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CGH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define CGH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: src/cgh_pkg.sv
// shared constants and types for the codepoint glyph hash map
`timescale 1ns / 1ps
package cgh_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int STYLE_COUNT = 4;
    localparam int CFG_COUNT   = 4;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int STYLE_W     = 2;
    localparam int CP_W        = 21;
    localparam int IDX_W       = 16;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CAPV_W      = $clog2(TABLE_DEPTH + 1);
    localparam int MEM_DEPTH   = STYLE_COUNT * TABLE_DEPTH;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int ENTRY_W     = 1 + IDX_W + CP_W;
    localparam int CNT_W       = 13;
    localparam int COUNT_MAX   = (1 << CNT_W) - 1;
    localparam int CAP_RESET   = 4093;
    localparam int CAP_MIN     = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [CFG_COUNT-1:0][CFG_W-1:0] cgh_caps_t;

    typedef struct packed {
        logic [STYLE_W-1:0] style;
        logic [CP_W-1:0]    cp;
        logic [IDX_W-1:0]   fidx;
        logic [CAPV_W-1:0]  cap;
        logic [SLOT_W-1:0]  h;
        logic [SLOT_W-1:0]  step;
        logic               no_table;
    } cgh_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] glyph_id;
        logic             hit;
        logic             inserted;
        logic             table_full;
    } cgh_result_t;

endpackage

FILE: src/cgh_front.sv
// front end: captures an item and computes first slot and probe step
`timescale 1ns / 1ps
module cgh_front import cgh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_push,
    input  logic [STYLE_W-1:0] in_style,
    input  logic [CP_W-1:0]    in_cp,
    input  logic [IDX_W-1:0]   in_fidx,
    input  cgh_caps_t          caps,
    output logic               busy,
    output logic               q_push,
    output cgh_item_t          q_item,
    input  logic               q_full
);

    localparam int DIG        = 3;
    localparam int STEPS      = CP_W / DIG;
    localparam int STEP_CNT_W = $clog2(STEPS);

    // restoring remainder, DIG dividend bits per call
    function automatic logic [CAPV_W-1:0] rem_digits(
        input logic [CAPV_W-1:0] r_in,
        input logic [DIG-1:0]    bits,
        input logic [CAPV_W-1:0] d
    );
        logic [CAPV_W:0]   t;
        logic [CAPV_W-1:0] r;
        r = r_in;
        for (int i = DIG - 1; i >= 0; i--)
        begin
            t = {r, bits[i]};
            if (t >= {1'b0, d})
            begin
                t = t - {1'b0, d};
            end
            r = t[CAPV_W-1:0];
        end
        return r;
    endfunction

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic [CP_W-1:0]       dvd_reg;
    logic [CAPV_W-1:0]     r1_reg;
    logic [CAPV_W-1:0]     r2_reg;
    logic [CAPV_W-1:0]     r1_next;
    logic [CAPV_W-1:0]     r2_next;
    logic [STYLE_W-1:0]    style_reg;
    logic [CP_W-1:0]       cp_reg;
    logic [IDX_W-1:0]      fidx_reg;
    logic [CAPV_W-1:0]     cap_reg;
    logic                  no_table_reg;
    logic [CFG_W-1:0]      cap_raw;
    logic [CAPV_W-1:0]     cap_clamp;
    logic [CAPV_W-1:0]     cap_less2;
    logic [DIG-1:0]        digits;
    logic                  load;

    assign load    = !busy_reg && in_push;
    assign cap_raw = caps[in_style];

    always_comb
    begin
        priority if (32'(cap_raw) < CAP_MIN)
        begin
            cap_clamp = CAPV_W'(CAP_MIN);
        end
        else if (32'(cap_raw) > TABLE_DEPTH)
        begin
            cap_clamp = CAPV_W'(TABLE_DEPTH);
        end
        else
        begin
            cap_clamp = CAPV_W'(cap_raw);
        end
    end

    assign cap_less2 = cap_reg - CAPV_W'(2);
    assign digits    = dvd_reg[CP_W-1 -: DIG];
    assign r1_next   = rem_digits(r1_reg, digits, cap_reg);
    assign r2_next   = rem_digits(r2_reg, digits, cap_less2);

    assign busy            = busy_reg;
    assign q_push          = done_reg;
    assign q_item.style    = style_reg;
    assign q_item.cp       = cp_reg;
    assign q_item.fidx     = fidx_reg;
    assign q_item.cap      = cap_reg;
    assign q_item.h        = r1_reg[SLOT_W-1:0];
    assign q_item.step     = (r2_reg == '0) ? SLOT_W'(1) : r2_reg[SLOT_W-1:0];
    assign q_item.no_table = no_table_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (!busy_reg)
        begin
            if (in_push)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
        end
        else if (!done_reg)
        begin
            cnt_reg <= cnt_reg + STEP_CNT_W'(1);
            if (cnt_reg == STEP_CNT_W'(STEPS - 1))
            begin
                done_reg <= 1'b1;
            end
        end
        else if (!q_full)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            style_reg    <= in_style;
            cp_reg       <= in_cp;
            fidx_reg     <= in_fidx;
            cap_reg      <= cap_clamp;
            dvd_reg      <= in_cp;
            r1_reg       <= '0;
            r2_reg       <= '0;
            no_table_reg <= (32'(in_style) >= STYLE_COUNT);
        end
        else if (busy_reg && !done_reg)
        begin
            dvd_reg <= dvd_reg << DIG;
            r1_reg  <= r1_next;
            r2_reg  <= r2_next;
        end
    end

endmodule

FILE: src/cgh_queue.sv
// small fifo between front end and probe engine
`timescale 1ns / 1ps
module cgh_queue import cgh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cgh_item_t din,
    output logic      full,
    input  logic      pop,
    output cgh_item_t dout,
    output logic      empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    cgh_item_t          slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_QW-1:0]  count_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_QW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_QW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_QW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: src/cgh_back.sv
// probe engine: table memory, probe sequencer, counters and result register
`timescale 1ns / 1ps
`include "codepoint_glyph_hash_map_assert.svh"
module cgh_back import cgh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  cgh_item_t   q_item,
    output logic        q_pop,
    output cgh_result_t res,
    output logic        res_valid,
    input  logic        res_pop,
    output logic        clearing
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam int SUM_W = SLOT_W + 1;

    function automatic logic [ADDR_W-1:0] make_addr(
        input logic [STYLE_W-1:0] style,
        input logic [SLOT_W-1:0]  slot
    );
        return ADDR_W'(ADDR_W'(style) * ADDR_W'(TABLE_DEPTH) + ADDR_W'(slot));
    endfunction

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;
    logic [ADDR_W-1:0]               clr_reg;
    cgh_item_t                       cur_reg;
    logic [SLOT_W-1:0]               h_reg;
    logic [CAPV_W-1:0]               n_reg;
    logic [ENTRY_W-1:0]              mem [MEM_DEPTH];
    logic [ENTRY_W-1:0]              rd_data_reg;
    logic [ADDR_W-1:0]               rd_addr;
    logic [ADDR_W-1:0]               wr_addr;
    logic [ENTRY_W-1:0]              wr_data;
    logic                            wr_en;
    logic [STYLE_COUNT-1:0][CNT_W-1:0] count_reg;
    cgh_result_t                     res_reg;
    cgh_result_t                     res_data;
    logic                            res_valid_reg;
    logic                            res_load;
    logic                            e_valid;
    logic [CP_W-1:0]                 e_cp;
    logic [IDX_W-1:0]                e_glyph;
    logic [SUM_W-1:0]                h_sum;
    logic [SLOT_W-1:0]               h_adv;
    logic                            start;
    logic                            stop;
    logic                            last;
    logic                            do_insert;

    assign e_valid = rd_data_reg[ENTRY_W-1];
    assign e_glyph = rd_data_reg[CP_W +: IDX_W];
    assign e_cp    = rd_data_reg[CP_W-1:0];

    assign h_sum = {1'b0, h_reg} + {1'b0, cur_reg.step};
    assign h_adv = (h_sum >= SUM_W'(cur_reg.cap)) ? SLOT_W'(h_sum - SUM_W'(cur_reg.cap))
                                                  : h_sum[SLOT_W-1:0];

    assign start     = (state_reg == ST_IDLE) && !q_empty && !res_valid_reg;
    assign stop      = !e_valid || (e_cp == cur_reg.cp);
    assign last      = (n_reg == cur_reg.cap - CAPV_W'(1));
    assign do_insert = (state_reg == ST_CHECK) && !e_valid && (cur_reg.fidx != '0);

    assign q_pop     = start;
    assign clearing  = (state_reg == ST_CLEAR);
    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        res_load   = 1'b0;
        res_data   = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == ADDR_W'(MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (q_item.no_table)
                    begin
                        res_load = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (stop)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (e_valid)
                    begin
                        res_data.glyph_id = e_glyph;
                        res_data.hit      = 1'b1;
                    end
                    else if (cur_reg.fidx != '0)
                    begin
                        res_data.glyph_id = cur_reg.fidx;
                        res_data.inserted = 1'b1;
                    end
                end
                else if (last)
                begin
                    res_load            = 1'b1;
                    res_data.table_full = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_CHECK)
        begin
            rd_addr = make_addr(cur_reg.style, h_adv);
        end
        else
        begin
            rd_addr = make_addr(q_item.style, q_item.h);
        end
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = do_insert;
            wr_addr = make_addr(cur_reg.style, h_reg);
            wr_data = {1'b1, cur_reg.fidx, cur_reg.cp};
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            n_reg         <= '0;
            res_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (start)
            begin
                n_reg <= '0;
            end
            else if (state_reg == ST_CHECK && !stop)
            begin
                n_reg <= n_reg + CAPV_W'(1);
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_pop)
            begin
                res_valid_reg <= 1'b0;
            end
            for (int s = 0; s < STYLE_COUNT; s++)
            begin
                if (do_insert && (32'(cur_reg.style) == s)
                    && (count_reg[s] != CNT_W'(COUNT_MAX)))
                begin
                    count_reg[s] <= count_reg[s] + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_reg <= q_item;
            h_reg   <= q_item.h;
        end
        else if (state_reg == ST_CHECK && !stop)
        begin
            h_reg <= h_adv;
        end
        if (res_load)
        begin
            res_reg <= res_data;
        end
    end

    `CGH_ASSERT_IMPL(a_slot_in_range, clk, rst_n, state_reg == ST_CHECK, SUM_W'(h_reg) < SUM_W'(cur_reg.cap), "probe slot beyond capacity")
    `CGH_ASSERT_IMPL(a_probe_bound, clk, rst_n, state_reg == ST_CHECK, n_reg < cur_reg.cap, "probe count beyond capacity")
    `CGH_ASSERT_IMPL(a_one_flag, clk, rst_n, res_valid_reg, $countones({res_reg.hit, res_reg.inserted, res_reg.table_full}) <= 1, "more than one result flag")
    `CGH_ASSERT_NEXT(a_load_empty, clk, rst_n, res_valid_reg && !res_pop, !res_load || !$past(res_valid_reg), "result overwritten")

endmodule

FILE: src/codepoint_glyph_hash_map.sv
// top level of the codepoint glyph hash map
`timescale 1ns / 1ps
// Per-style open-addressing glyph map with double hashing. After reset the
// table memory is swept clear, one entry a cycle, through all 16384 entries;
// full stays high during that pass while configuration writes are still
// taken. An item then passes the front end, which works out codepoint mod
// capacity and mod (capacity - 2) three dividend bits a cycle, and then the
// probe engine, which after a setup step probes the table memory one slot at
// a time; that memory has one read and one write port. Front and probe engine
// overlap through a two-entry queue. Capacities must be changed only while
// the block is idle; the block itself does not enforce this.
module codepoint_glyph_hash_map import cgh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [STYLE_W-1:0]   style,
    input  logic [CP_W-1:0]      codepoint,
    input  logic [IDX_W-1:0]     font_glyph,
    output logic                 empty,
    input  logic                 pop,
    output logic [IDX_W-1:0]     glyph_id,
    output logic                 hit,
    output logic                 inserted,
    output logic                 table_full,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cgh_caps_t   caps_reg;
    logic        front_busy;
    logic        clearing;
    logic        fq_push;
    cgh_item_t   fq_item;
    logic        fq_full;
    logic        qb_empty;
    cgh_item_t   qb_item;
    logic        qb_pop;
    cgh_result_t res;
    logic        res_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_COUNT; i++)
            begin
                caps_reg[i] <= CFG_W'(CAP_RESET);
            end
        end
        else if (cfg_valid)
        begin
            caps_reg[cfg_index] <= cfg_data;
        end
    end

    assign full = front_busy || clearing;

    cgh_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_push  (push && !full),
        .in_style (style),
        .in_cp    (codepoint),
        .in_fidx  (font_glyph),
        .caps     (caps_reg),
        .busy     (front_busy),
        .q_push   (fq_push),
        .q_item   (fq_item),
        .q_full   (fq_full)
    );

    cgh_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .din   (fq_item),
        .full  (fq_full),
        .pop   (qb_pop),
        .dout  (qb_item),
        .empty (qb_empty)
    );

    cgh_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (qb_empty),
        .q_item    (qb_item),
        .q_pop     (qb_pop),
        .res       (res),
        .res_valid (res_valid),
        .res_pop   (pop),
        .clearing  (clearing)
    );

    assign empty      = !res_valid;
    assign glyph_id   = res.glyph_id;
    assign hit        = res.hit;
    assign inserted   = res.inserted;
    assign table_full = res.table_full;

endmodule
